### rtl/core/lzrod_pkg.sv
// package for the lzss relative offset decoder: state type, register codes,
// reset values of the configuration registers and shared widths
// no dependencies
package lzrod_pkg;

  localparam int MAX_INDEX_BITS_DEF = 12;
  localparam int DATA_W             = 8;
  localparam int CFG_IDX_W          = 3;
  localparam int CFG_DATA_W         = 24;
  localparam int CNT_W              = 24;
  localparam int COPY_W             = 6;   // a copy is at most 48 bytes
  localparam int FLAG_W             = 9;

  // configuration register indexes
  localparam logic [CFG_IDX_W-1:0] REG_INDEX_BITS  = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_LENGTH_BITS = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_MIN_MATCH   = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_START_BACK  = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_FILL_BYTE   = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_OUT_LIMIT   = 3'd5;

  // register values after reset
  localparam logic [3:0]        RST_INDEX_BITS  = 4'd12;
  localparam logic [2:0]        RST_LENGTH_BITS = 3'd4;
  localparam logic [4:0]        RST_MIN_MATCH   = 5'd2;
  localparam logic [4:0]        RST_START_BACK  = 5'd2;
  localparam logic [7:0]        RST_FILL_BYTE   = 8'h20;
  localparam logic [CNT_W-1:0]  RST_OUT_LIMIT   = 24'hffffff;

  localparam logic [FLAG_W-1:0] FLAG_MARK = 9'h100;

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_PROC,
    ST_COPY_RD,
    ST_COPY_WR,
    ST_DONE
  } state_t;

endpackage

### rtl/core/lzrod_ram.sv
// generic single write port ram with one registered read port
// no dependencies
module lzrod_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 4096
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

### rtl/core/lzss_relative_offset_decoder_top.sv
// lzss decoder with relative match offsets over a circular byte window
// depends on lzrod_pkg and lzrod_ram
//
//  channel  | dir | beat contents                               | accepted when
//  s_axis   | in  | tdata: data_byte; tuser: first_byte; tlast: | tvalid & tready
//           |     | last_byte                                   |
//  m_axis   | out | tdata: out_byte; tlast: run_end             | tvalid & tready
//  cfg      | in  | cfg_index selects register, cfg_data value  | cfg_we
//
// a flag, literal or length byte passes the process and done steps from acceptance
// to the next ready; a match byte adds a window read step, then an emit and write
// back step, per copied byte, for a copy of up to 48 bytes
// a beat with first_byte set first sweeps all 2**MAX_INDEX_BITS window entries
// with the fill byte, one entry a cycle, before it is decoded
// reset runs the same sweep with no beat pending; s_axis stays not ready until
// it ends, cfg writes are taken
// a stalled m_axis holds the sequencer only at a literal or copy emit step
module lzss_relative_offset_decoder_top #(
  parameter int MAX_INDEX_BITS = lzrod_pkg::MAX_INDEX_BITS_DEF
) (
  input  logic                             clk,
  input  logic                             rst,
  // compressed input
  input  logic                             s_axis_tvalid,
  output logic                             s_axis_tready,
  input  logic [lzrod_pkg::DATA_W-1:0]     s_axis_tdata,  // [7:0] data_byte
  input  logic                             s_axis_tuser,  // [0] first_byte
  input  logic                             s_axis_tlast,
  // decompressed output
  output logic                             m_axis_tvalid,
  input  logic                             m_axis_tready,
  output logic [lzrod_pkg::DATA_W-1:0]     m_axis_tdata,  // [7:0] out_byte
  output logic                             m_axis_tlast,
  // configuration writes
  input  logic                             cfg_we,
  input  logic [lzrod_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [lzrod_pkg::CFG_DATA_W-1:0] cfg_data
);

  import lzrod_pkg::*;

  localparam int AW    = MAX_INDEX_BITS;
  localparam int DEPTH = 1 << MAX_INDEX_BITS;
  // write position after reset, worked out from the reset register values
  localparam int RST_IB  = (int'(RST_INDEX_BITS) > MAX_INDEX_BITS) ? MAX_INDEX_BITS
                                                                   : int'(RST_INDEX_BITS);
  localparam int RST_POS = ((1 << RST_IB) - (1 << int'(RST_LENGTH_BITS))
                            - int'(RST_START_BACK)) & ((1 << RST_IB) - 1);

  // configuration registers
  logic [3:0]        index_bits;
  logic [2:0]        length_bits;
  logic [4:0]        min_match;
  logic [4:0]        start_back;
  logic [7:0]        fill_byte;
  logic [CNT_W-1:0]  output_limit;

  always_ff @(posedge clk) begin
    if (rst) begin
      index_bits   <= RST_INDEX_BITS;
      length_bits  <= RST_LENGTH_BITS;
      min_match    <= RST_MIN_MATCH;
      start_back   <= RST_START_BACK;
      fill_byte    <= RST_FILL_BYTE;
      output_limit <= RST_OUT_LIMIT;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_INDEX_BITS:  index_bits   <= cfg_data[3:0];
        REG_LENGTH_BITS: length_bits  <= cfg_data[2:0];
        REG_MIN_MATCH:   min_match    <= cfg_data[4:0];
        REG_START_BACK:  start_back   <= cfg_data[4:0];
        REG_FILL_BYTE:   fill_byte    <= cfg_data[7:0];
        REG_OUT_LIMIT:   output_limit <= cfg_data[CNT_W-1:0];
        default: ;
      endcase
    end
  end

  // saturated register values
  logic [4:0]    ib_eff;
  logic [2:0]    lb_eff;
  logic [4:0]    mm_eff;
  logic [AW-1:0] win_mask;

  always_comb begin
    if (index_bits < 4'd8) begin
      ib_eff = 5'd8;
    end else if ({1'b0, index_bits} > 5'(MAX_INDEX_BITS)) begin
      ib_eff = 5'(MAX_INDEX_BITS);
    end else begin
      ib_eff = {1'b0, index_bits};
    end
    if (length_bits < 3'd2) begin
      lb_eff = 3'd2;
    end else if (length_bits > 3'd5) begin
      lb_eff = 3'd5;
    end else begin
      lb_eff = length_bits;
    end
    mm_eff   = (min_match > 5'd16) ? 5'd16 : min_match;
    win_mask = ~({AW{1'b1}} << ib_eff);
  end

  // sequencer and decoder state
  state_t            state, state_next;
  logic              pend, pend_next;          // a beat waits behind the sweep
  logic [AW-1:0]     clr_addr, clr_addr_next;
  logic [7:0]        clr_fill, clr_fill_next;
  logic [7:0]        in_data, in_data_next;
  logic              in_last, in_last_next;
  logic [AW-1:0]     write_pos, write_pos_next;
  logic [FLAG_W-1:0] flag_shift, flag_shift_next;
  logic              token_phase, token_phase_next;
  logic [7:0]        held_length, held_length_next;
  logic [CNT_W-1:0]  out_count, out_count_next;
  logic              halted, halted_next;
  logic [AW-1:0]     src, src_next;
  logic [COPY_W-1:0] left, left_next;
  logic              out_valid, out_valid_next;
  logic [7:0]        out_byte, out_byte_next;
  logic              out_last, out_last_next;

  // window memory ports
  logic              ram_we, ram_re;
  logic [AW-1:0]     ram_waddr, ram_raddr;
  logic [7:0]        ram_wdata, ram_rdata;

  lzrod_ram #(
    .WIDTH (DATA_W),
    .DEPTH (DEPTH)
  ) u_window (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .re    (ram_re),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  // match token arithmetic for the distance byte step, with the output limit and free checks
  logic [5:0]        span;
  logic [AW-1:0]     start_pos;
  logic [15:0]       back_dist;
  logic [7:0]        len_field;
  logic [COPY_W-1:0] copy_len;
  logic [CNT_W-1:0]  room;
  logic              cut_short;
  logic [COPY_W-1:0] copy_emit;
  logic              out_free;
  logic              under_limit;
  logic              emit;
  logic              accept;

  always_comb begin
    span        = 6'd1 << lb_eff;
    start_pos   = (AW'(0) - AW'(span) - AW'(start_back)) & win_mask;
    back_dist   = (16'(in_data) << lb_eff) | 16'(held_length >> lb_eff);
    len_field   = held_length & ~(8'hff << lb_eff);
    copy_len    = COPY_W'(len_field) + COPY_W'(mm_eff) + COPY_W'(1);
    under_limit = out_count < output_limit;
    room        = under_limit ? (output_limit - out_count) : '0;
    cut_short   = CNT_W'(copy_len) > room;
    copy_emit   = cut_short ? room[COPY_W-1:0] : copy_len;
    out_free    = !out_valid || m_axis_tready;
  end

  assign accept        = s_axis_tvalid && s_axis_tready;
  assign s_axis_tready = (state == ST_IDLE);
  assign m_axis_tvalid = out_valid;
  assign m_axis_tdata  = out_byte;
  assign m_axis_tlast  = out_last;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_CLEAR;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next       = state;
    pend_next        = pend;
    clr_addr_next    = clr_addr;
    clr_fill_next    = clr_fill;
    in_data_next     = in_data;
    in_last_next     = in_last;
    write_pos_next   = write_pos;
    flag_shift_next  = flag_shift;
    token_phase_next = token_phase;
    held_length_next = held_length;
    out_count_next   = out_count;
    halted_next      = halted;
    src_next         = src;
    left_next        = left;
    out_valid_next   = out_valid && !m_axis_tready;
    out_byte_next    = out_byte;
    out_last_next    = out_last;
    ram_we           = 1'b0;
    ram_waddr        = write_pos & win_mask;
    ram_wdata        = in_data;
    ram_re           = 1'b0;
    ram_raddr        = src;
    emit             = 1'b0;

    case (state)
      ST_CLEAR: begin
        ram_we        = 1'b1;
        ram_waddr     = clr_addr;
        ram_wdata     = clr_fill;
        clr_addr_next = clr_addr + AW'(1);
        if (clr_addr == {AW{1'b1}}) begin
          state_next = pend ? ST_PROC : ST_IDLE;
          pend_next  = 1'b0;
        end
      end

      ST_IDLE: begin
        if (accept) begin
          in_data_next = s_axis_tdata;
          in_last_next = s_axis_tlast;
          if (s_axis_tuser) begin
            // stream start: restart the decoder and sweep the window
            state_next       = ST_CLEAR;
            pend_next        = 1'b1;
            clr_addr_next    = '0;
            clr_fill_next    = fill_byte;
            write_pos_next   = start_pos;
            flag_shift_next  = '0;
            token_phase_next = 1'b0;
            held_length_next = '0;
            out_count_next   = '0;
            halted_next      = 1'b0;
          end else begin
            state_next = ST_PROC;
          end
        end
      end

      ST_PROC: begin
        if (halted) begin
          state_next = ST_DONE;
        end else if (!token_phase) begin
          if (flag_shift <= FLAG_W'(1)) begin
            flag_shift_next = FLAG_MARK | FLAG_W'(in_data);
            state_next      = ST_DONE;
          end else if (flag_shift[0]) begin
            // literal
            if (!under_limit) begin
              flag_shift_next = flag_shift >> 1;
              halted_next     = 1'b1;
              state_next      = ST_DONE;
            end else if (out_free) begin
              flag_shift_next = flag_shift >> 1;
              emit            = 1'b1;
              ram_we          = 1'b1;
              out_valid_next  = 1'b1;
              out_byte_next   = in_data;
              out_last_next   = 1'b1;
              write_pos_next  = (write_pos + AW'(1)) & win_mask;
              out_count_next  = out_count + CNT_W'(1);
              state_next      = ST_DONE;
            end
          end else begin
            held_length_next = in_data;
            token_phase_next = 1'b1;
            state_next       = ST_DONE;
          end
        end else begin
          // distance byte: set up the copy
          flag_shift_next  = flag_shift >> 1;
          token_phase_next = 1'b0;
          src_next         = (write_pos - back_dist[AW-1:0]) & win_mask;
          left_next        = copy_emit;
          if (cut_short) begin
            halted_next = 1'b1;
          end
          state_next = (copy_emit == '0) ? ST_DONE : ST_COPY_RD;
        end
      end

      ST_COPY_RD: begin
        ram_re     = 1'b1;
        state_next = ST_COPY_WR;
      end

      ST_COPY_WR: begin
        if (out_free) begin
          emit           = 1'b1;
          ram_we         = 1'b1;
          ram_wdata      = ram_rdata;
          out_valid_next = 1'b1;
          out_byte_next  = ram_rdata;
          out_last_next  = (left == COPY_W'(1));
          write_pos_next = (write_pos + AW'(1)) & win_mask;
          out_count_next = out_count + CNT_W'(1);
          src_next       = (src + AW'(1)) & win_mask;
          left_next      = left - COPY_W'(1);
          state_next     = (left == COPY_W'(1)) ? ST_DONE : ST_COPY_RD;
        end
      end

      ST_DONE: begin
        if (in_last) begin
          halted_next      = 1'b1;
          token_phase_next = 1'b0;
        end
        state_next = ST_IDLE;
      end

      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      pend        <= 1'b0;
      clr_addr    <= '0;
      clr_fill    <= RST_FILL_BYTE;
      write_pos   <= AW'(RST_POS);
      flag_shift  <= '0;
      token_phase <= 1'b0;
      held_length <= '0;
      out_count   <= '0;
      halted      <= 1'b0;
      left        <= '0;
      out_valid   <= 1'b0;
    end else begin
      pend        <= pend_next;
      clr_addr    <= clr_addr_next;
      clr_fill    <= clr_fill_next;
      write_pos   <= write_pos_next;
      flag_shift  <= flag_shift_next;
      token_phase <= token_phase_next;
      held_length <= held_length_next;
      out_count   <= out_count_next;
      halted      <= halted_next;
      left        <= left_next;
      out_valid   <= out_valid_next;
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    in_data  <= in_data_next;
    in_last  <= in_last_next;
    src      <= src_next;
    out_byte <= out_byte_next;
    out_last <= out_last_next;
  end

  // a copy in flight always has bytes left to move
  a_copy_left: assert property (@(posedge clk) disable iff (rst)
    (state == ST_COPY_RD || state == ST_COPY_WR) |-> (left != '0))
    else $error("copy step with no bytes left");

  // no byte leaves once the stream has reached its output limit
  a_emit_limit: assert property (@(posedge clk) disable iff (rst)
    emit |-> (out_count < output_limit))
    else $error("byte emitted beyond output limit");

  // the window sweep ends after its last entry
  a_clear_end: assert property (@(posedge clk) disable iff (rst)
    (state == ST_CLEAR && clr_addr == {AW{1'b1}}) |=> (state != ST_CLEAR))
    else $error("window sweep did not end");

  // a fresh byte never overwrites one still waiting on m_axis
  a_no_overrun: assert property (@(posedge clk) disable iff (rst)
    emit |-> (!out_valid || m_axis_tready))
    else $error("output register overrun");

endmodule
